// ===== rtl/rgbis_pkg.sv =====
// rgbis_pkg: shared widths, codes and lane control types for the rgb region statistics unit
// no dependencies

package rgbis_pkg;

   localparam int DIM_W          = 9;
   localparam int COORD_W        = 8;
   localparam int PIX_W          = 8;
   localparam int PIX_SQ_W       = 16;
   localparam int SUM_W          = 24;
   localparam int SQ_TAB_W       = 33;
   localparam int SQ_W           = 32;
   localparam int AREA_W         = 18;
   localparam int PROD_W         = 48;
   localparam int FRAC_BITS      = 8;
   localparam int DIV_W          = 56;
   localparam int DIV_CNT_W      = $clog2(DIV_W + 2);
   localparam int DEV_W          = 40;
   localparam int DEV_TOTAL_W    = 42;
   localparam int ERR_W          = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RECT       = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NOT_LOADED = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_FILL,
      OP_CORNER_SET,
      OP_CORNER_ADD,
      OP_CORNER_SUB,
      OP_SQUARE,
      OP_DIV_AVG,
      OP_DIV_DEV,
      OP_DIV_STEP,
      OP_AVG_DONE,
      OP_DEV_DONE
   } lane_op_type;

   typedef struct packed {
      lane_op_type op;
      logic        use_left;
      logic        use_up;
      logic        left_fwd;
   } lane_ctrl_type;

endpackage

// ===== rtl/rgbis_ram.sv =====
// rgbis_ram: generic single write port, single read port memory with registered read
// no dependencies

module rgbis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rgbis_div.sv =====
// rgbis_div: restoring divider, one quotient bit per step
// depends on rgbis_pkg

module rgbis_div (
   input  logic                         clock,
   input  logic                         start,
   input  logic                         step,
   input  logic [rgbis_pkg::DIV_W-1:0]  dividend,
   input  logic [rgbis_pkg::AREA_W-1:0] divisor,
   output logic [rgbis_pkg::DIV_W-1:0]  quotient
);

   logic [rgbis_pkg::DIV_W-1:0]  dq_ff;
   logic [rgbis_pkg::DIV_W-1:0]  dq_in;
   logic [rgbis_pkg::AREA_W-1:0] rem_ff;
   logic [rgbis_pkg::AREA_W-1:0] rem_in;
   logic [rgbis_pkg::AREA_W-1:0] divisor_ff;
   logic [rgbis_pkg::AREA_W-1:0] divisor_in;
   logic [rgbis_pkg::AREA_W:0]   rem_shift;
   logic                         fits;

   always_comb begin
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      rem_shift  = {rem_ff, dq_ff[rgbis_pkg::DIV_W-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      if (start) begin
         dq_in      = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (step) begin
         if (fits) begin
            rem_in = rgbis_pkg::AREA_W'(rem_shift - {1'b0, divisor_ff});
         end else begin
            rem_in = rem_shift[rgbis_pkg::AREA_W-1:0];
         end
         dq_in = {dq_ff[rgbis_pkg::DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = dq_ff;

endmodule

// ===== rtl/rgbis_lane.sv =====
// rgbis_lane: one color channel, value and square tables, region sums, divider and deviation
// depends on rgbis_pkg, rgbis_ram, rgbis_div

module rgbis_lane #(
   parameter int DEPTH = rgbis_pkg::DEF_MAX_WIDTH * rgbis_pkg::DEF_MAX_HEIGHT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  rgbis_pkg::lane_ctrl_type          ctrl,
   input  logic [rgbis_pkg::PIX_W-1:0]       pixel,
   input  logic [AW-1:0]                     rd_addr,
   input  logic [AW-1:0]                     wr_addr,
   input  logic [rgbis_pkg::AREA_W-1:0]      area,
   output logic [rgbis_pkg::SUM_W-1:0]       sum,
   output logic [rgbis_pkg::SQ_W-1:0]        square_sum,
   output logic [rgbis_pkg::PIX_W-1:0]       avg,
   output logic [rgbis_pkg::DEV_W-1:0]       dev
);

   logic [rgbis_pkg::SUM_W-1:0]    sum_rd;
   logic [rgbis_pkg::SQ_TAB_W-1:0] sq_rd;
   logic [rgbis_pkg::SUM_W-1:0]    sum_fill;
   logic [rgbis_pkg::SQ_TAB_W-1:0] sq_fill;
   logic [rgbis_pkg::PIX_SQ_W-1:0] pix_sq;
   logic                           fill_en;
   logic                           div_start;
   logic [rgbis_pkg::DIV_W-1:0]    dividend;
   logic [rgbis_pkg::DIV_W-1:0]    quotient;
   logic [rgbis_pkg::DEV_W-1:0]    q_scaled;

   logic [rgbis_pkg::SUM_W-1:0]    sum_up_ff;
   logic [rgbis_pkg::SUM_W-1:0]    sum_ul_ff;
   logic [rgbis_pkg::SQ_TAB_W-1:0] sq_up_ff;
   logic [rgbis_pkg::SQ_TAB_W-1:0] sq_ul_ff;
   logic [rgbis_pkg::SUM_W-1:0]    sum_acc_ff;
   logic [rgbis_pkg::SQ_W-1:0]     sq_acc_ff;
   logic [rgbis_pkg::PROD_W-1:0]   prod_ff;
   logic [rgbis_pkg::PIX_W-1:0]    avg_ff;
   logic [rgbis_pkg::DEV_W-1:0]    dev_ff;

   always_comb begin
      pix_sq   = rgbis_pkg::PIX_SQ_W'(pixel * pixel);
      sum_fill = rgbis_pkg::SUM_W'(pixel);
      sq_fill  = rgbis_pkg::SQ_TAB_W'(pix_sq);
      if (ctrl.use_left) begin
         // left entry still being written in single-row images
         sum_fill = sum_fill + (ctrl.left_fwd ? sum_up_ff : sum_rd);
         sq_fill  = sq_fill + (ctrl.left_fwd ? sq_up_ff : sq_rd);
      end
      if (ctrl.use_up) begin
         sum_fill = sum_fill + sum_up_ff;
         sq_fill  = sq_fill + sq_up_ff;
      end
      if (ctrl.use_left && ctrl.use_up) begin
         sum_fill = sum_fill - sum_ul_ff;
         sq_fill  = sq_fill - sq_ul_ff;
      end
      fill_en   = ctrl.op == rgbis_pkg::OP_FILL;
      div_start = (ctrl.op == rgbis_pkg::OP_DIV_AVG) || (ctrl.op == rgbis_pkg::OP_DIV_DEV);
      if (ctrl.op == rgbis_pkg::OP_DIV_DEV) begin
         dividend = {prod_ff, {rgbis_pkg::FRAC_BITS{1'b0}}};
      end else begin
         dividend = rgbis_pkg::DIV_W'(sum_acc_ff);
      end
      q_scaled = {sq_acc_ff, {rgbis_pkg::FRAC_BITS{1'b0}}};
   end

   rgbis_ram #(.WIDTH(rgbis_pkg::SUM_W), .DEPTH(DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (fill_en),
      .wr_addr (wr_addr),
      .wr_data (sum_fill),
      .rd_addr (rd_addr),
      .rd_data (sum_rd)
   );

   rgbis_ram #(.WIDTH(rgbis_pkg::SQ_TAB_W), .DEPTH(DEPTH)) u_sq_ram (
      .clock   (clock),
      .wr_en   (fill_en),
      .wr_addr (wr_addr),
      .wr_data (sq_fill),
      .rd_addr (rd_addr),
      .rd_data (sq_rd)
   );

   rgbis_div u_div (
      .clock    (clock),
      .start    (div_start),
      .step     (ctrl.op == rgbis_pkg::OP_DIV_STEP),
      .dividend (dividend),
      .divisor  (area),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      case (ctrl.op)
         rgbis_pkg::OP_FILL: begin
            sum_up_ff <= sum_fill;
            sum_ul_ff <= sum_rd;
            sq_up_ff  <= sq_fill;
            sq_ul_ff  <= sq_rd;
         end
         rgbis_pkg::OP_CORNER_SET: begin
            sum_acc_ff <= sum_rd;
            sq_acc_ff  <= sq_rd[rgbis_pkg::SQ_W-1:0];
         end
         rgbis_pkg::OP_CORNER_ADD: begin
            sum_acc_ff <= sum_acc_ff + sum_rd;
            sq_acc_ff  <= sq_acc_ff + sq_rd[rgbis_pkg::SQ_W-1:0];
         end
         rgbis_pkg::OP_CORNER_SUB: begin
            sum_acc_ff <= sum_acc_ff - sum_rd;
            sq_acc_ff  <= sq_acc_ff - sq_rd[rgbis_pkg::SQ_W-1:0];
         end
         rgbis_pkg::OP_SQUARE: begin
            prod_ff <= sum_acc_ff * sum_acc_ff;
         end
         rgbis_pkg::OP_AVG_DONE: begin
            avg_ff <= quotient[rgbis_pkg::PIX_W-1:0];
         end
         rgbis_pkg::OP_DEV_DONE: begin
            if (quotient <= rgbis_pkg::DIV_W'(q_scaled)) begin
               dev_ff <= q_scaled - quotient[rgbis_pkg::DEV_W-1:0];
            end else begin
               dev_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign sum        = sum_acc_ff;
   assign square_sum = sq_acc_ff;
   assign avg        = avg_ff;
   assign dev        = dev_ff;

endmodule

// ===== rtl/rgb_integral_image_region_stats_unit.sv =====
// rgb_integral_image_region_stats_unit: top level, load and query sequencer, three channel lanes,
// deviation merge and result register; depends on rgbis_pkg and rgbis_lane
//
//  channel  ports        beat
//  req      req_*        load one pixel (column-major) or query one rectangle
//  rsp      rsp_*        one result for each query, none for a load
//  csr      csr_*        write image_width (index 0) or image_height (index 1)
//
// loads stream back to back (one table read and one write per lane)
// a query runs four corner reads, one square, two divider passes of 56 steps each in every
// lane, then the result register
// a query flagged with an error goes from accept straight to the result register
// reset clears the load position and the loaded flag; the tables need no clearing
// loads are taken while a result waits on rsp; a query then holds until the result is taken

module rgb_integral_image_region_stats_unit #(
   parameter int MAX_WIDTH  = rgbis_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rgbis_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_action,
   input  logic [rgbis_pkg::PIX_W-1:0]            req_red,
   input  logic [rgbis_pkg::PIX_W-1:0]            req_green,
   input  logic [rgbis_pkg::PIX_W-1:0]            req_blue,
   input  logic [rgbis_pkg::COORD_W-1:0]          req_left,
   input  logic [rgbis_pkg::COORD_W-1:0]          req_top,
   input  logic [rgbis_pkg::DIM_W-1:0]            req_rect_width,
   input  logic [rgbis_pkg::DIM_W-1:0]            req_rect_height,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rgbis_pkg::SUM_W-1:0]            rsp_sum_red,
   output logic [rgbis_pkg::SUM_W-1:0]            rsp_sum_green,
   output logic [rgbis_pkg::SUM_W-1:0]            rsp_sum_blue,
   output logic [rgbis_pkg::SQ_W-1:0]             rsp_square_sum_red,
   output logic [rgbis_pkg::SQ_W-1:0]             rsp_square_sum_green,
   output logic [rgbis_pkg::SQ_W-1:0]             rsp_square_sum_blue,
   output logic [rgbis_pkg::PIX_W-1:0]            rsp_avg_red,
   output logic [rgbis_pkg::PIX_W-1:0]            rsp_avg_green,
   output logic [rgbis_pkg::PIX_W-1:0]            rsp_avg_blue,
   output logic [rgbis_pkg::DEV_TOTAL_W-1:0]      rsp_deviation_total,
   output logic [rgbis_pkg::ERR_W-1:0]            rsp_error_code,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rgbis_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rgbis_pkg::DIM_W-1:0]            csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = rgbis_pkg::DIM_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_DIV_AVG,
      ST_DIV_DEV,
      ST_SETTLE,
      ST_OUT
   } state_type;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int maxv);
      logic [DW-1:0] r;
      r = v;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > maxv) begin
         r = DW'(maxv);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] tab_addr(input logic [DW-1:0] x, input logic [DW-1:0] y);
      return AW'(32'(x) * MAX_HEIGHT + 32'(y));
   endfunction

   state_type                       state_ff, state_in;
   logic [DW-1:0]                   width_ff, width_in;
   logic [DW-1:0]                   height_ff, height_in;
   logic [DW-1:0]                   col_ff, col_in;
   logic [DW-1:0]                   row_ff, row_in;
   logic                            loaded_ff, loaded_in;
   logic [rgbis_pkg::PIX_W-1:0]     red_ff, red_in;
   logic [rgbis_pkg::PIX_W-1:0]     green_ff, green_in;
   logic [rgbis_pkg::PIX_W-1:0]     blue_ff, blue_in;
   rgbis_pkg::lane_ctrl_type        ctrl_ff, ctrl_in;
   logic [AW-1:0]                   wr_addr_ff, wr_addr_in;
   logic [AW-1:0]                   rd_addr;
   logic [DW-1:0]                   x0_ff, x0_in;
   logic [DW-1:0]                   y0_ff, y0_in;
   logic [DW-1:0]                   x1_ff, x1_in;
   logic [DW-1:0]                   y1_ff, y1_in;
   logic [rgbis_pkg::AREA_W-1:0]    area_ff, area_in;
   logic [1:0]                      corner_ff, corner_in;
   logic [rgbis_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [rgbis_pkg::ERR_W-1:0]     err_ff, err_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rgbis_pkg::SUM_W-1:0]     rsp_sum_r_ff, rsp_sum_r_in;
   logic [rgbis_pkg::SUM_W-1:0]     rsp_sum_g_ff, rsp_sum_g_in;
   logic [rgbis_pkg::SUM_W-1:0]     rsp_sum_b_ff, rsp_sum_b_in;
   logic [rgbis_pkg::SQ_W-1:0]      rsp_sq_r_ff, rsp_sq_r_in;
   logic [rgbis_pkg::SQ_W-1:0]      rsp_sq_g_ff, rsp_sq_g_in;
   logic [rgbis_pkg::SQ_W-1:0]      rsp_sq_b_ff, rsp_sq_b_in;
   logic [rgbis_pkg::PIX_W-1:0]     rsp_avg_r_ff, rsp_avg_r_in;
   logic [rgbis_pkg::PIX_W-1:0]     rsp_avg_g_ff, rsp_avg_g_in;
   logic [rgbis_pkg::PIX_W-1:0]     rsp_avg_b_ff, rsp_avg_b_in;
   logic [rgbis_pkg::DEV_TOTAL_W-1:0] rsp_dev_ff, rsp_dev_in;
   logic [rgbis_pkg::ERR_W-1:0]     rsp_err_ff, rsp_err_in;

   logic [rgbis_pkg::SUM_W-1:0]     lane_sum [3];
   logic [rgbis_pkg::SQ_W-1:0]      lane_sq [3];
   logic [rgbis_pkg::PIX_W-1:0]     lane_avg [3];
   logic [rgbis_pkg::DEV_W-1:0]     lane_dev [3];
   logic [rgbis_pkg::PIX_W-1:0]     lane_pix [3];

   logic [DW-1:0]                   ld_col;
   logic [DW-1:0]                   ld_row;
   logic [DW:0]                     ld_row_next;
   logic [DW:0]                     ld_col_next;
   logic [DW:0]                     x_end;
   logic [DW:0]                     y_end;
   logic [DW-1:0]                   x0m;
   logic [DW-1:0]                   y0m;
   logic                            rect_bad;

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      loaded_in    = loaded_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      ctrl_in      = '{op: rgbis_pkg::OP_NONE, use_left: 1'b0, use_up: 1'b0, left_fwd: 1'b0};
      wr_addr_in   = wr_addr_ff;
      rd_addr      = '0;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      area_in      = area_ff;
      corner_in    = corner_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_r_in = rsp_sum_r_ff;
      rsp_sum_g_in = rsp_sum_g_ff;
      rsp_sum_b_in = rsp_sum_b_ff;
      rsp_sq_r_in  = rsp_sq_r_ff;
      rsp_sq_g_in  = rsp_sq_g_ff;
      rsp_sq_b_in  = rsp_sq_b_ff;
      rsp_avg_r_in = rsp_avg_r_ff;
      rsp_avg_g_in = rsp_avg_g_ff;
      rsp_avg_b_in = rsp_avg_b_ff;
      rsp_dev_in   = rsp_dev_ff;
      rsp_err_in   = rsp_err_ff;

      if ((col_ff >= width_ff) || (row_ff >= height_ff)) begin
         ld_col = '0;
         ld_row = '0;
      end else begin
         ld_col = col_ff;
         ld_row = row_ff;
      end
      ld_row_next = {1'b0, ld_row} + 1'b1;
      ld_col_next = {1'b0, ld_col} + 1'b1;
      x_end       = {2'b00, req_left} + {1'b0, req_rect_width};
      y_end       = {2'b00, req_top} + {1'b0, req_rect_height};
      rect_bad    = (req_rect_width == '0) || (req_rect_height == '0) ||
                    (x_end > {1'b0, width_ff}) || (y_end > {1'b0, height_ff});
      x0m         = (x0_ff == '0) ? '0 : x0_ff - 1'b1;
      y0m         = (y0_ff == '0) ? '0 : y0_ff - 1'b1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == rgbis_pkg::ACT_LOAD) begin
                  if ((ld_col == '0) && (ld_row == '0)) begin
                     loaded_in = 1'b0;
                  end
                  red_in           = req_red;
                  green_in         = req_green;
                  blue_in          = req_blue;
                  rd_addr          = tab_addr((ld_col == '0) ? '0 : ld_col - 1'b1, ld_row);
                  wr_addr_in       = tab_addr(ld_col, ld_row);
                  ctrl_in.op       = rgbis_pkg::OP_FILL;
                  ctrl_in.use_left = ld_col != '0;
                  ctrl_in.use_up   = ld_row != '0;
                  ctrl_in.left_fwd = (ctrl_ff.op == rgbis_pkg::OP_FILL) &&
                                     (rd_addr == wr_addr_ff);
                  if (ld_row_next >= {1'b0, height_ff}) begin
                     row_in = '0;
                     if (ld_col_next >= {1'b0, width_ff}) begin
                        col_in    = '0;
                        loaded_in = 1'b1;
                     end else begin
                        col_in = ld_col_next[DW-1:0];
                     end
                  end else begin
                     row_in = ld_row_next[DW-1:0];
                     col_in = ld_col;
                  end
               end else if (!loaded_ff) begin
                  err_in   = rgbis_pkg::ERR_NOT_LOADED;
                  state_in = ST_OUT;
               end else if (rect_bad) begin
                  err_in   = rgbis_pkg::ERR_RECT;
                  state_in = ST_OUT;
               end else begin
                  err_in    = rgbis_pkg::ERR_NONE;
                  x0_in     = DW'(req_left);
                  y0_in     = DW'(req_top);
                  x1_in     = DW'(x_end - 1'b1);
                  y1_in     = DW'(y_end - 1'b1);
                  area_in   = rgbis_pkg::AREA_W'(req_rect_width * req_rect_height);
                  corner_in = '0;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            case (corner_ff)
               2'd0: begin
                  rd_addr    = tab_addr(x1_ff, y1_ff);
                  ctrl_in.op = rgbis_pkg::OP_CORNER_SET;
               end
               2'd1: begin
                  rd_addr = tab_addr(x0m, y1_ff);
                  if (x0_ff != '0) begin
                     ctrl_in.op = rgbis_pkg::OP_CORNER_SUB;
                  end
               end
               2'd2: begin
                  rd_addr = tab_addr(x1_ff, y0m);
                  if (y0_ff != '0) begin
                     ctrl_in.op = rgbis_pkg::OP_CORNER_SUB;
                  end
               end
               default: begin
                  rd_addr = tab_addr(x0m, y0m);
                  if ((x0_ff != '0) && (y0_ff != '0)) begin
                     ctrl_in.op = rgbis_pkg::OP_CORNER_ADD;
                  end
               end
            endcase
            corner_in = corner_ff + 1'b1;
            if (corner_ff == 2'd3) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            ctrl_in.op = rgbis_pkg::OP_SQUARE;
            cnt_in     = '0;
            state_in   = ST_DIV_AVG;
         end
         ST_DIV_AVG: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               ctrl_in.op = rgbis_pkg::OP_DIV_AVG;
            end else if (cnt_ff <= rgbis_pkg::DIV_CNT_W'(rgbis_pkg::DIV_W)) begin
               ctrl_in.op = rgbis_pkg::OP_DIV_STEP;
            end else begin
               ctrl_in.op = rgbis_pkg::OP_AVG_DONE;
               cnt_in     = '0;
               state_in   = ST_DIV_DEV;
            end
         end
         ST_DIV_DEV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               ctrl_in.op = rgbis_pkg::OP_DIV_DEV;
            end else if (cnt_ff <= rgbis_pkg::DIV_CNT_W'(rgbis_pkg::DIV_W)) begin
               ctrl_in.op = rgbis_pkg::OP_DIV_STEP;
            end else begin
               ctrl_in.op = rgbis_pkg::OP_DEV_DONE;
               cnt_in     = '0;
               state_in   = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               if (err_ff == rgbis_pkg::ERR_NONE) begin
                  rsp_sum_r_in = lane_sum[0];
                  rsp_sum_g_in = lane_sum[1];
                  rsp_sum_b_in = lane_sum[2];
                  rsp_sq_r_in  = lane_sq[0];
                  rsp_sq_g_in  = lane_sq[1];
                  rsp_sq_b_in  = lane_sq[2];
                  rsp_avg_r_in = lane_avg[0];
                  rsp_avg_g_in = lane_avg[1];
                  rsp_avg_b_in = lane_avg[2];
                  rsp_dev_in   = rgbis_pkg::DEV_TOTAL_W'(lane_dev[0]) +
                                 rgbis_pkg::DEV_TOTAL_W'(lane_dev[1]) +
                                 rgbis_pkg::DEV_TOTAL_W'(lane_dev[2]);
               end else begin
                  rsp_sum_r_in = '0;
                  rsp_sum_g_in = '0;
                  rsp_sum_b_in = '0;
                  rsp_sq_r_in  = '0;
                  rsp_sq_g_in  = '0;
                  rsp_sq_b_in  = '0;
                  rsp_avg_r_in = '0;
                  rsp_avg_g_in = '0;
                  rsp_avg_b_in = '0;
                  rsp_dev_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            rgbis_pkg::CSR_IMAGE_WIDTH: begin
               width_in  = clamp_dim(csr_data, MAX_WIDTH);
               col_in    = '0;
               row_in    = '0;
               loaded_in = 1'b0;
            end
            rgbis_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = clamp_dim(csr_data, MAX_HEIGHT);
               col_in    = '0;
               row_in    = '0;
               loaded_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= clamp_dim(DW'(256), MAX_WIDTH);
         height_ff    <= clamp_dim(DW'(256), MAX_HEIGHT);
         col_ff       <= '0;
         row_ff       <= '0;
         loaded_ff    <= 1'b0;
         ctrl_ff      <= '{op: rgbis_pkg::OP_NONE, use_left: 1'b0, use_up: 1'b0,
                           left_fwd: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         loaded_ff    <= loaded_in;
         ctrl_ff      <= ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      wr_addr_ff   <= wr_addr_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      area_ff      <= area_in;
      corner_ff    <= corner_in;
      cnt_ff       <= cnt_in;
      err_ff       <= err_in;
      rsp_sum_r_ff <= rsp_sum_r_in;
      rsp_sum_g_ff <= rsp_sum_g_in;
      rsp_sum_b_ff <= rsp_sum_b_in;
      rsp_sq_r_ff  <= rsp_sq_r_in;
      rsp_sq_g_ff  <= rsp_sq_g_in;
      rsp_sq_b_ff  <= rsp_sq_b_in;
      rsp_avg_r_ff <= rsp_avg_r_in;
      rsp_avg_g_ff <= rsp_avg_g_in;
      rsp_avg_b_ff <= rsp_avg_b_in;
      rsp_dev_ff   <= rsp_dev_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign lane_pix[0] = red_ff;
   assign lane_pix[1] = green_ff;
   assign lane_pix[2] = blue_ff;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      rgbis_lane #(.DEPTH(DEPTH)) u_lane (
         .clock      (clock),
         .ctrl       (ctrl_ff),
         .pixel      (lane_pix[g]),
         .rd_addr    (rd_addr),
         .wr_addr    (wr_addr_ff),
         .area       (area_ff),
         .sum        (lane_sum[g]),
         .square_sum (lane_sq[g]),
         .avg        (lane_avg[g]),
         .dev        (lane_dev[g])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sum_red          = rsp_sum_r_ff;
   assign rsp_sum_green        = rsp_sum_g_ff;
   assign rsp_sum_blue         = rsp_sum_b_ff;
   assign rsp_square_sum_red   = rsp_sq_r_ff;
   assign rsp_square_sum_green = rsp_sq_g_ff;
   assign rsp_square_sum_blue  = rsp_sq_b_ff;
   assign rsp_avg_red          = rsp_avg_r_ff;
   assign rsp_avg_green        = rsp_avg_g_ff;
   assign rsp_avg_blue         = rsp_avg_b_ff;
   assign rsp_deviation_total  = rsp_dev_ff;
   assign rsp_error_code       = rsp_err_ff;

endmodule

// ===== test/testbench.sv =====
// testbench for rgb_integral_image_region_stats_unit: loads images, queries rectangles and
// checks every result against a behavioral predictor of the summed-area tables
// depends on rgbis_pkg and the rtl of the unit

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rgbis_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd2;
   localparam int QUERY_LAT = 150;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAB_DEPTH = rgbis_pkg::DEF_MAX_WIDTH * rgbis_pkg::DEF_MAX_HEIGHT;

   typedef struct packed {
      logic [rgbis_pkg::SUM_W-1:0]       sum_r, sum_g, sum_b;
      logic [rgbis_pkg::SQ_W-1:0]        sq_r, sq_g, sq_b;
      logic [rgbis_pkg::PIX_W-1:0]       avg_r, avg_g, avg_b;
      logic [rgbis_pkg::DEV_TOTAL_W-1:0] dev;
      logic [rgbis_pkg::ERR_W-1:0]       err;
   } stats_type;

   typedef struct {
      logic       act;
      logic [7:0] r, g, b, l, t;
      logic [8:0] w, h;
      bit         typed;
      logic [1:0] code;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_action = 0;
   logic [rgbis_pkg::PIX_W-1:0] req_red = 0, req_green = 0, req_blue = 0;
   logic [rgbis_pkg::COORD_W-1:0] req_left = 0, req_top = 0;
   logic [rgbis_pkg::DIM_W-1:0] req_rect_width = 0, req_rect_height = 0;
   logic req_ready, rsp_valid;
   logic rsp_ready = 0;
   logic [rgbis_pkg::SUM_W-1:0] rsp_sum_red, rsp_sum_green, rsp_sum_blue;
   logic [rgbis_pkg::SQ_W-1:0] rsp_square_sum_red, rsp_square_sum_green, rsp_square_sum_blue;
   logic [rgbis_pkg::PIX_W-1:0] rsp_avg_red, rsp_avg_green, rsp_avg_blue;
   logic [rgbis_pkg::DEV_TOTAL_W-1:0] rsp_deviation_total;
   logic [rgbis_pkg::ERR_W-1:0] rsp_error_code;
   logic csr_valid = 0;
   logic csr_ready;
   logic [rgbis_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [rgbis_pkg::DIM_W-1:0] csr_data = 0;

   rgb_integral_image_region_stats_unit i_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // predictor state
   logic [rgbis_pkg::SUM_W-1:0]    sum_tab [3][TAB_DEPTH];
   logic [rgbis_pkg::SQ_TAB_W-1:0] sq_tab [3][TAB_DEPTH];
   int  img_w, img_h, load_col, load_row;
   bit  img_loaded;
   stats_type expected_stats[$];
   bit  cur_typed;
   logic [1:0] cur_code;
   int  mismatches, cycles, item_count;
   bit  no_idle;
   int  rsp_stall;

   function automatic int clamp_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int taddr(int x, int y);
      return (x * rgbis_pkg::DEF_MAX_HEIGHT + y) % TAB_DEPTH;
   endfunction

   task automatic table_load(logic [7:0] pix[3]);
      logic [rgbis_pkg::SUM_W-1:0] s;
      logic [rgbis_pkg::SQ_TAB_W-1:0] q;
      if (load_col >= img_w || load_row >= img_h) begin
         load_col = 0;
         load_row = 0;
      end
      if (load_col == 0 && load_row == 0) img_loaded = 0;
      for (int c = 0; c < 3; c++) begin
         s = pix[c];
         q = pix[c] * pix[c];
         if (load_col > 0) begin
            s += sum_tab[c][taddr(load_col-1, load_row)];
            q += sq_tab[c][taddr(load_col-1, load_row)];
         end
         if (load_row > 0) begin
            s += sum_tab[c][taddr(load_col, load_row-1)];
            q += sq_tab[c][taddr(load_col, load_row-1)];
         end
         if (load_col > 0 && load_row > 0) begin
            s -= sum_tab[c][taddr(load_col-1, load_row-1)];
            q -= sq_tab[c][taddr(load_col-1, load_row-1)];
         end
         sum_tab[c][taddr(load_col, load_row)] = s;
         sq_tab[c][taddr(load_col, load_row)] = q;
      end
      load_row++;
      if (load_row >= img_h) begin
         load_row = 0;
         load_col++;
         if (load_col >= img_w) begin
            load_col = 0;
            img_loaded = 1;
         end
      end
   endtask

   function automatic stats_type region_stats(int l, int t, int w, int h);
      stats_type st;
      logic [rgbis_pkg::SUM_W-1:0] s[3];
      logic [rgbis_pkg::SQ_TAB_W-1:0] q33;
      logic [rgbis_pkg::SQ_W-1:0] q[3];
      logic [rgbis_pkg::PIX_W-1:0] a[3];
      longint unsigned area, frac, dev, ss;
      int x1, y1;
      st = '0;
      if (!img_loaded) begin
         st.err = rgbis_pkg::ERR_NOT_LOADED;
         return st;
      end
      if (w == 0 || h == 0 || l + w > img_w || t + h > img_h) begin
         st.err = rgbis_pkg::ERR_RECT;
         return st;
      end
      x1 = l + w - 1;
      y1 = t + h - 1;
      area = w * h;
      dev = 0;
      for (int c = 0; c < 3; c++) begin
         s[c] = sum_tab[c][taddr(x1, y1)];
         q33 = sq_tab[c][taddr(x1, y1)];
         if (l > 0) begin
            s[c] -= sum_tab[c][taddr(l-1, y1)];
            q33 -= sq_tab[c][taddr(l-1, y1)];
         end
         if (t > 0) begin
            s[c] -= sum_tab[c][taddr(x1, t-1)];
            q33 -= sq_tab[c][taddr(x1, t-1)];
         end
         if (l > 0 && t > 0) begin
            s[c] += sum_tab[c][taddr(l-1, t-1)];
            q33 += sq_tab[c][taddr(l-1, t-1)];
         end
         q[c] = q33[rgbis_pkg::SQ_W-1:0];
         ss = s[c];
         frac = (ss * ss * 256) / area;
         if (frac <= longint'(q[c]) * 256) dev += longint'(q[c]) * 256 - frac;
         a[c] = rgbis_pkg::PIX_W'(ss / area);
      end
      st.sum_r = s[0]; st.sum_g = s[1]; st.sum_b = s[2];
      st.sq_r = q[0]; st.sq_g = q[1]; st.sq_b = q[2];
      st.avg_r = a[0]; st.avg_g = a[1]; st.avg_b = a[2];
      st.dev = dev[rgbis_pkg::DEV_TOTAL_W-1:0];
      st.err = rgbis_pkg::ERR_NONE;
      return st;
   endfunction

   // accepted beats: predict on input, check on output
   always @(posedge clock) begin
      stats_type got, exp_st;
      logic [7:0] pix[3];
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == rgbis_pkg::CSR_IMAGE_WIDTH ||
             csr_index == rgbis_pkg::CSR_IMAGE_HEIGHT) begin
            if (csr_index == rgbis_pkg::CSR_IMAGE_WIDTH) begin
               img_w = clamp_dim(csr_data, rgbis_pkg::DEF_MAX_WIDTH);
            end else begin
               img_h = clamp_dim(csr_data, rgbis_pkg::DEF_MAX_HEIGHT);
            end
            load_col = 0;
            load_row = 0;
            img_loaded = 0;
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (req_action == rgbis_pkg::ACT_LOAD) begin
            pix[0] = req_red; pix[1] = req_green; pix[2] = req_blue;
            table_load(pix);
         end else begin
            exp_st = region_stats(req_left, req_top, req_rect_width, req_rect_height);
            if (cur_typed) begin
               exp_st = '0;
               exp_st.err = cur_code;
            end
            expected_stats.push_back(exp_st);
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_sum_red, rsp_sum_green, rsp_sum_blue, rsp_square_sum_red,
                rsp_square_sum_green, rsp_square_sum_blue, rsp_avg_red, rsp_avg_green,
                rsp_avg_blue, rsp_deviation_total, rsp_error_code};
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %p", got);
         end else begin
            exp_st = expected_stats.pop_front();
            if (got !== exp_st) begin
               mismatches++;
               if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", exp_st, got);
            end
         end
      end
   end

   // result-side backpressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready = 0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
         rsp_stall = $urandom_range(0, 3);
         rsp_ready = 0;
      end else begin
         rsp_ready = 1;
      end
   end

   task automatic send_beat(row_type rw);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1;
      req_action = rw.act;
      req_red = rw.r; req_green = rw.g; req_blue = rw.b;
      req_left = rw.l; req_top = rw.t;
      req_rect_width = rw.w; req_rect_height = rw.h;
      cur_typed = rw.typed;
      cur_code = rw.code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      item_count++;
   endtask

   function automatic row_type pixel_row(logic [7:0] r, g, b);
      row_type rw;
      rw = '{act: rgbis_pkg::ACT_LOAD, r: r, g: g, b: b, l: 0, t: 0, w: 0, h: 0, typed: 0,
             code: rgbis_pkg::ERR_NONE};
      return rw;
   endfunction

   function automatic row_type query_row(int l, t, w, h, bit typed = 0,
                                         logic [1:0] code = rgbis_pkg::ERR_NONE);
      row_type rw;
      rw = '{act: rgbis_pkg::ACT_QUERY, r: rgbis_pkg::PIX_W'($urandom),
             g: rgbis_pkg::PIX_W'($urandom), b: rgbis_pkg::PIX_W'($urandom),
             l: rgbis_pkg::COORD_W'(l), t: rgbis_pkg::COORD_W'(t),
             w: rgbis_pkg::DIM_W'(w), h: rgbis_pkg::DIM_W'(h), typed: typed, code: code};
      return rw;
   endfunction

   task automatic wait_drained();
      req_valid = 0;
      while (expected_stats.size() != 0) @(negedge clock);
      repeat (QUERY_LAT) @(negedge clock);
   endtask

   task automatic write_reg(logic [rgbis_pkg::CSR_IDX_W-1:0] idx,
                            logic [rgbis_pkg::DIM_W-1:0] val);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic random_query(bit in_bounds);
      int w, h;
      if (in_bounds) begin
         w = $urandom_range(1, img_w);
         h = $urandom_range(1, img_h);
         send_beat(query_row($urandom_range(0, img_w - w), $urandom_range(0, img_h - h), w, h));
      end else begin
         send_beat(query_row($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 256), $urandom_range(0, 256)));
      end
   endtask

   task automatic load_pixels(int n, bit saturated);
      for (int i = 0; i < n; i++) begin
         if (saturated) send_beat(pixel_row(8'hff, 8'hff, 8'hff));
         else send_beat(pixel_row(rgbis_pkg::PIX_W'($urandom), rgbis_pkg::PIX_W'($urandom),
                                  rgbis_pkg::PIX_W'($urandom)));
         if (!saturated && $urandom_range(0, 19) == 0) random_query($urandom_range(0, 1));
      end
   endtask

   task automatic run_image(logic [rgbis_pkg::DIM_W-1:0] wv, logic [rgbis_pkg::DIM_W-1:0] hv,
                            bit saturated, int nq);
      int npix, k;
      wait_drained();
      if ($urandom_range(0, 1)) begin
         write_reg(rgbis_pkg::CSR_IMAGE_WIDTH, wv);
         write_reg(rgbis_pkg::CSR_IMAGE_HEIGHT, hv);
      end else begin
         write_reg(rgbis_pkg::CSR_IMAGE_HEIGHT, hv);
         write_reg(rgbis_pkg::CSR_IMAGE_WIDTH, wv);
      end
      if ($urandom_range(0, 3) == 0) begin
         write_reg(rgbis_pkg::CSR_IDX_W'(CSR_UNUSED + $urandom_range(0, 1)),
                   rgbis_pkg::DIM_W'($urandom));
      end
      npix = img_w * img_h;
      load_pixels(npix, saturated);
      if (saturated) send_beat(query_row(0, 0, img_w, img_h));
      for (int i = 0; i < nq; i++) random_query($urandom_range(0, 4) != 0);
      if (!saturated && npix > 1 && $urandom_range(0, 2) == 0) begin
         k = $urandom_range(1, npix - 1);
         load_pixels(k, 0);
         random_query(1);
         load_pixels(npix - k, 0);
         for (int i = 0; i < 3; i++) random_query(1);
      end
   endtask

   initial begin
      row_type directed[$];
      img_w = clamp_dim(256, rgbis_pkg::DEF_MAX_WIDTH);
      img_h = clamp_dim(256, rgbis_pkg::DEF_MAX_HEIGHT);
      repeat (6) @(negedge clock);
      reset = 0;

      send_beat(query_row(0, 0, 1, 1, 1, rgbis_pkg::ERR_NOT_LOADED));
      wait_drained();
      write_reg(rgbis_pkg::CSR_IMAGE_WIDTH, 2);
      write_reg(rgbis_pkg::CSR_IMAGE_HEIGHT, 2);
      directed.push_back(pixel_row(8'h00, 8'h00, 8'h00));
      directed.push_back(pixel_row(8'hff, 8'hff, 8'hff));
      directed.push_back(query_row(0, 0, 1, 1, 1, rgbis_pkg::ERR_NOT_LOADED));
      directed.push_back(pixel_row(8'hff, 8'h00, 8'h80));
      directed.push_back(pixel_row(8'h01, 8'h80, 8'hff));
      directed.push_back(query_row(0, 0, 2, 2));
      directed.push_back(query_row(1, 1, 1, 1));
      directed.push_back(query_row(0, 1, 2, 1));
      directed.push_back(query_row(1, 0, 1, 2));
      directed.push_back(query_row(0, 0, 0, 1, 1, rgbis_pkg::ERR_RECT));
      directed.push_back(query_row(0, 0, 1, 0, 1, rgbis_pkg::ERR_RECT));
      directed.push_back(query_row(1, 0, 2, 1, 1, rgbis_pkg::ERR_RECT));
      directed.push_back(query_row(0, 2, 1, 1, 1, rgbis_pkg::ERR_RECT));
      directed.push_back(query_row(255, 255, 256, 256, 1, rgbis_pkg::ERR_RECT));
      directed.push_back(query_row(0, 0, 256, 256, 1, rgbis_pkg::ERR_RECT));
      directed.push_back(pixel_row(8'h55, 8'haa, 8'h0f));
      directed.push_back(query_row(0, 0, 1, 1, 1, rgbis_pkg::ERR_NOT_LOADED));
      foreach (directed[i]) send_beat(directed[i]);

      // one saturated column of the largest height, given as an out-of-range value
      run_image(1, 511, 1, 4);
      run_image(0, 0, 0, 3);
      while (item_count < 390) run_image($urandom_range(1, 8), $urandom_range(1, 8), 0,
                                         $urandom_range(4, 10));
      no_idle = 1;
      run_image($urandom_range(1, 8), $urandom_range(1, 8), 0, 8);
      wait_drained();

      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
